// ----- sv/rms_level_meter_assert.svh -----
// Assertion macros shared by the RMS level meter checker.
`ifndef RMS_LEVEL_METER_ASSERT_SVH
`define RMS_LEVEL_METER_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define RMSLM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RMSLM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rmslm_pkg.sv -----
// Package with sizes, sequencer states and shared types of the RMS level meter.
`timescale 1ns / 1ps
package rmslm_pkg;

	localparam int MAX_SAMPLES = 65536;
	localparam int SAMPLE_BITS = 24;

	// field widths on the ports
	localparam int SAMPLE_W = 24;
	localparam int RMS_W    = 24;

	localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
	localparam int SUM_W   = SQ_W + $clog2(MAX_SAMPLES);

	// divide then root: one quotient bit per step, one root bit per step
	localparam int DIV_STEPS  = SUM_W;
	localparam int SQRT_STEPS = (SUM_W + 1) / 2;
	localparam int ROOT_W     = SQRT_STEPS;
	localparam int WORK_W     = 2 * SQRT_STEPS;
	localparam int REM_W      = ROOT_W + 2;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETTLE,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ds_stat_t;

	typedef struct packed {
		logic [RMS_W-1:0] rms;
		logic             empty_res;
		logic             overflowed;
	} rms_res_t;

endpackage

// ----- sv/rms_level_meter.sv -----
// RMS level meter: sample accumulator, divide/root sequencer and result register.
// Add transaction: accepted every cycle while idle; square is registered, then accumulated.
// Read transaction: settle, SUM_W (63) divide and (SUM_W+1)/2 (32) root steps, output state;
//   no divide or root if empty. Result valid once output free; input not ready meanwhile.
// All steps share one compare-subtract unit; result register frees input unless a result waits.
// arst_n clears accumulator, count, drop flag, sequencer and output valid.
`timescale 1ns / 1ps
module rms_level_meter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] sample
	input  logic [0:0]  s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [23:0] rms
	output logic [1:0]  m_tuser    // [0] empty_res, [1] overflowed
);
	import rmslm_pkg::*;

	logic               in_acc;
	logic               add_en;
	logic               start;
	logic               clear_acc;
	logic               out_free;
	logic [SUM_W-1:0]   sum;
	logic [COUNT_W-1:0] count;
	logic               dropped;
	ds_stat_t           stat;
	rms_res_t           res;

	logic               m_vld_q;
	rms_res_t           m_res_q;

	assign s_tready = !stat.busy;
	assign in_acc   = s_tvalid && s_tready;
	assign add_en   = in_acc && (s_tuser[0] == OP_ADD);
	assign start    = in_acc && (s_tuser[0] == OP_READ);
	assign out_free = !m_vld_q || m_tready;

	rmslm_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.add_en  (add_en),
		.sample  (s_tdata),
		.clear   (clear_acc),
		.sum     (sum),
		.count   (count),
		.dropped (dropped)
	);

	rmslm_divsqrt u_ds (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sum       (sum),
		.count     (count),
		.dropped   (dropped),
		.out_free  (out_free),
		.clear_acc (clear_acc),
		.stat      (stat),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_vld_q <= 1'b0;
		else if (stat.done)
			m_vld_q <= 1'b1;
		else if (m_tready)
			m_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (stat.done)
			m_res_q <= res;
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = m_res_q.rms;
	assign m_tuser  = {m_res_q.overflowed, m_res_q.empty_res};

endmodule

// ----- sv/rmslm_mac.sv -----
// Sample squaring stage, sum-of-squares accumulator, sample counter and drop flag.
`timescale 1ns / 1ps
module rmslm_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          add_en,
	input  logic [rmslm_pkg::SAMPLE_W-1:0] sample,
	input  logic                          clear,
	output logic [rmslm_pkg::SUM_W-1:0]   sum,
	output logic [rmslm_pkg::COUNT_W-1:0] count,
	output logic                          dropped
);
	import rmslm_pkg::*;

	logic [SAMPLE_BITS-1:0]   smp;
	logic [SAMPLE_BITS-1:0]   mag;
	logic [2*SAMPLE_BITS-1:0] prod;
	logic                     full;

	logic [SQ_W-1:0]    sq_s1;
	logic               sq_vld_s1;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;
	logic               dropped_q;

	assign smp  = sample[SAMPLE_BITS-1:0];
	assign mag  = smp[SAMPLE_BITS-1] ? (~smp + 1'b1) : smp;
	assign prod = mag * mag;
	assign full = (count_q >= COUNT_W'(MAX_SAMPLES));

	always_ff @(posedge clk) begin
		sq_s1 <= prod[SQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s1 <= 1'b0;
			sum_q     <= '0;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			sq_vld_s1 <= add_en && !full;
			if (clear) begin
				sum_q     <= '0;
				count_q   <= '0;
				dropped_q <= 1'b0;
			end else begin
				if (sq_vld_s1)
					sum_q <= sum_q + SUM_W'(sq_s1);
				if (add_en) begin
					if (full)
						dropped_q <= 1'b1;
					else
						count_q <= count_q + 1'b1;
				end
			end
		end
	end

	assign sum     = sum_q;
	assign count   = count_q;
	assign dropped = dropped_q;

endmodule

// ----- sv/rmslm_divsqrt.sv -----
// Sequencer with one shared compare-subtract unit: restoring divide, then digit-by-digit root.
`timescale 1ns / 1ps
module rmslm_divsqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rmslm_pkg::SUM_W-1:0]   sum,
	input  logic [rmslm_pkg::COUNT_W-1:0] count,
	input  logic                          dropped,
	input  logic                          out_free,
	output logic                          clear_acc,
	output rmslm_pkg::ds_stat_t           stat,
	output rmslm_pkg::rms_res_t           res
);
	import rmslm_pkg::*;

	seq_state_t state_q, state_d;

	logic [WORK_W-1:0]  work_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [COUNT_W-1:0] div_q;
	logic [STEP_W-1:0]  step_q;
	logic               empty_q;
	logic               ovf_q;

	// shared unit
	logic [REM_W-1:0] op_a;
	logic [REM_W-1:0] op_b;
	logic [REM_W:0]   diff;
	logic             ge;

	always_comb begin
		if (state_q == ST_SQRT) begin
			op_a = {rem_q[REM_W-3:0], work_q[WORK_W-1 -: 2]};
			op_b = {root_q, 2'b01};
		end else begin
			op_a = REM_W'({rem_q[COUNT_W-1:0], work_q[SUM_W-1]});
			op_b = REM_W'(div_q);
		end
	end

	assign diff = {1'b0, op_a} - {1'b0, op_b};
	assign ge   = !diff[REM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		clear_acc = 1'b0;
		stat.busy = 1'b1;
		stat.done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				stat.busy = 1'b0;
				if (start)
					state_d = ST_SETTLE;
			end
			ST_SETTLE: begin
				clear_acc = 1'b1;
				state_d   = (count == '0) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1))
					state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (step_q == STEP_W'(SQRT_STEPS - 1))
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					stat.done = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SETTLE: begin
				work_q  <= WORK_W'(sum);
				div_q   <= count;
				empty_q <= (count == '0);
				ovf_q   <= dropped;
				rem_q   <= '0;
				root_q  <= '0;
				step_q  <= '0;
			end
			ST_DIV: begin
				// quotient bits shift in where dividend bits leave
				work_q <= WORK_W'({work_q[SUM_W-2:0], ge});
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					step_q <= '0;
					rem_q  <= '0;
				end else begin
					step_q <= step_q + 1'b1;
					rem_q  <= ge ? diff[REM_W-1:0] : op_a;
				end
			end
			ST_SQRT: begin
				rem_q  <= ge ? diff[REM_W-1:0] : op_a;
				root_q <= {root_q[ROOT_W-2:0], ge};
				work_q <= {work_q[WORK_W-3:0], 2'b00};
				step_q <= step_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign res.rms        = empty_q ? '0 : RMS_W'(root_q);
	assign res.empty_res  = empty_q;
	assign res.overflowed = ovf_q;

endmodule

// ----- sv/rmslm_checker.sv -----
// Port-level checker for the RMS level meter, bound to the top level.
`timescale 1ns / 1ps
`include "rms_level_meter_assert.svh"
module rmslm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import rmslm_pkg::*;

	// a read transaction occupies the sequencer
	`RMSLM_ASSERT_NEXT(a_read_busy, s_tvalid && s_tready && s_tuser[0] == OP_READ, !s_tready, "input ready right after a read transaction")
	// empty result carries zero level
	`RMSLM_ASSERT(a_empty_zero, !(m_tvalid && m_tuser[0]) || m_tdata == 24'd0, "empty result with nonzero rms")
	// level never exceeds full scale
	`RMSLM_ASSERT(a_rms_range, !m_tvalid || m_tdata <= 24'h800000, "rms above full scale")
	`RMSLM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind rms_level_meter rmslm_checker u_rmslm_checker (.*);

// ----- sim/rms_level_meter_checker.sv -----
// Checker for the RMS level meter: tracks the stream, predicts each reading and compares.
`timescale 1ns / 1ps
module rms_level_meter_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] sample
	input  logic [0:0]  s_tuser,   // [0] operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [23:0] rms
	input  logic [1:0]  m_tuser,   // [0] empty_res, [1] overflowed
	output int          mismatches,
	output int          outstanding
);
	import rmslm_pkg::*;

	logic [63:0] square_sum;
	logic [31:0] samples_held;
	logic        dropped;
	rms_res_t    rms_readings_due[$];

	function automatic logic [31:0] floor_root(input logic [63:0] x);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if ({32'd0, trial} * {32'd0, trial} <= x)
				root = trial;
		end
		return root;
	endfunction

	task automatic meter_absorb(input logic op, input logic [SAMPLE_W-1:0] smp);
		logic [63:0] mag;
		logic [31:0] root;
		rms_res_t    reading;
		if (op == OP_ADD) begin
			if (samples_held >= MAX_SAMPLES) begin
				dropped = 1'b1;
			end else begin
				mag = '0;
				mag[SAMPLE_BITS-1:0] = smp[SAMPLE_BITS-1:0];
				// negative: two's complement magnitude
				if (smp[SAMPLE_BITS-1])
					mag = (64'd1 << SAMPLE_BITS) - mag;
				square_sum = square_sum + mag * mag;
				samples_held = samples_held + 1;
			end
		end else begin
			reading.overflowed = dropped;
			if (samples_held == 0) begin
				reading.rms = '0;
				reading.empty_res = 1'b1;
			end else begin
				root = floor_root(square_sum / {32'd0, samples_held});
				reading.rms = root[RMS_W-1:0];
				reading.empty_res = 1'b0;
			end
			rms_readings_due.push_back(reading);
			square_sum = '0;
			samples_held = '0;
			dropped = 1'b0;
		end
	endtask

	task automatic check_reading();
		rms_res_t want;
		if (rms_readings_due.size() == 0) begin
			$error("reading with none expected: rms %0d, empty_res %0b, overflowed %0b",
				m_tdata, m_tuser[0], m_tuser[1]);
			mismatches++;
		end else begin
			want = rms_readings_due.pop_front();
			if (m_tdata !== want.rms) begin
				$error("rms: expected %0d, actual %0d", want.rms, m_tdata);
				mismatches++;
			end
			if (m_tuser[0] !== want.empty_res) begin
				$error("empty_res: expected %0b, actual %0b", want.empty_res, m_tuser[0]);
				mismatches++;
			end
			if (m_tuser[1] !== want.overflowed) begin
				$error("overflowed: expected %0b, actual %0b", want.overflowed, m_tuser[1]);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_sum = '0;
			samples_held = '0;
			dropped = 1'b0;
			rms_readings_due.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_reading();
			if (s_tvalid && s_tready)
				meter_absorb(s_tuser[0], s_tdata);
			outstanding = rms_readings_due.size();
		end
	end

endmodule

// ----- sim/rms_level_meter_test.sv -----
// Top of the RMS level meter testbench: clock, reset, stimulus, output flow control, verdict.
`timescale 1ns / 1ps
module rms_level_meter_test;
	import rmslm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [23:0] sample
	logic [0:0]  s_tuser;   // [0] operation
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [23:0] rms
	logic [1:0]  m_tuser;   // [0] empty_res, [1] overflowed

	int   mismatches;
	int   outstanding;
	logic hold_req;
	int   samples_fed;
	int   reads_fed;

	rms_level_meter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	rms_level_meter_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin : watchdog
		#16_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// output flow control: random runs, long ready stretches, and a long hold on request
	initial begin : result_sink
		int  left;
		int  pick;
		logic rdy;
		m_tready = 1'b0;
		rdy = 1'b0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rdy = 1'b0;
				left = 400;
			end else if (left == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					rdy = 1'b1;
					left = $urandom_range(50, 200);
				end else if (pick < 55) begin
					rdy = 1'b1;
					left = $urandom_range(1, 4);
				end else if (pick < 92) begin
					rdy = 1'b0;
					left = $urandom_range(1, 3);
				end else begin
					rdy = 1'b0;
					left = $urandom_range(10, 60);
				end
			end
			left--;
			m_tready <= rdy;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [23:0] pick_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return {{20{r[31]}}, r[3:0]};
			3: return {{12{r[31]}}, r[11:0]};
			default: return r[23:0];
		endcase
	endfunction

	task automatic feed(input logic op, input logic [23:0] smp, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= smp;
		do @(posedge clk); while (!s_tready);
		if (op == OP_READ)
			reads_fed++;
		else
			samples_fed++;
	endtask

	// stop offering and wait for every pending reading
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		int   seq;
		int   seq_len;
		int   kind;
		logic burst;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		hold_req = 1'b0;
		samples_fed = 0;
		reads_fed = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed
		feed(OP_READ, 24'h000000, 0);               // read with nothing accumulated
		feed(OP_ADD, 24'h7FFFFF, 0);
		feed(OP_READ, 24'h000000, 0);
		feed(OP_ADD, 24'h800000, 1);
		feed(OP_READ, 24'hFFFFFF, 0);               // sample field ignored on read
		feed(OP_ADD, 24'h000000, 0);
		feed(OP_READ, 24'h000000, 0);
		feed(OP_ADD, 24'h000001, 0);
		feed(OP_ADD, 24'hFFFFFF, 0);
		feed(OP_ADD, 24'h000003, 0);
		feed(OP_READ, 24'h000000, 0);
		feed(OP_READ, 24'h000000, 0);               // empty right after a clear
		feed(OP_ADD, 24'h555555, 0);
		feed(OP_ADD, 24'hAAAAAA, 2);
		feed(OP_ADD, 24'h123456, 0);
		feed(OP_READ, 24'h000000, 0);
		drain();

		// count exactly full at full scale, nothing dropped
		for (int n = 0; n < MAX_SAMPLES; n++)
			feed(OP_ADD, 24'h800000, 0);
		feed(OP_READ, 24'h000000, 0);
		// past full: samples dropped, flag reported once then cleared
		for (int n = 0; n < MAX_SAMPLES + 3; n++)
			feed(OP_ADD, pick_sample(), 0);
		feed(OP_READ, 24'h000000, 0);
		feed(OP_READ, 24'h000000, 0);
		drain();

		// random runs of samples, each closed by a read
		samples_fed = 0;
		reads_fed = 0;
		seq = 0;
		while (samples_fed + reads_fed < 700 || reads_fed < 48) begin
			seq++;
			kind = $urandom_range(0, 99);
			if (kind < 70)
				seq_len = $urandom_range(1, 12);
			else if (kind < 90)
				seq_len = $urandom_range(13, 60);
			else
				seq_len = 0;
			burst = ($urandom_range(0, 4) == 0);
			for (int n = 0; n < seq_len; n++)
				feed(OP_ADD, pick_sample(), burst ? 0 : pick_gap());
			feed(OP_READ, pick_sample(), burst ? 0 : pick_gap());
			// long receiver hold while reads keep coming: input must back up
			if (seq == 10 || seq == 40) begin
				hold_req = 1'b1;
				repeat (5) begin
					feed(OP_ADD, pick_sample(), 0);
					feed(OP_READ, pick_sample(), 0);
				end
			end
			if (seq % 15 == 0)
				drain();
		end

		drain();
		repeat (150) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
